@@ rtl/ovl_pkg.sv @@
// Shared types and constants for the ordered value list table.
// No dependencies; ovl_if, ovl_ctrl and the top level import this package.
package ovl_pkg;

	// List capacity and the widths that follow from it.
	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;

	// Request kinds.
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_DELETE = 2'd1;
	localparam logic [1:0] KIND_SEARCH = 2'd2;

	// Result status codes.
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_ABSENT = 2'd1;
	localparam logic [1:0] STAT_FULL   = 2'd2;

	// Request payload.
	typedef struct packed {
		logic [1:0]              kind;
		logic signed [VAL_W-1:0] value;
	} req_t;

	// Result payload.
	typedef struct packed {
		logic [1:0]              status;
		logic                    is_last;
		logic signed [VAL_W-1:0] next_value;
		logic [4:0]              count;
	} rsp_t;

	// Control of the element store, driven by the sequencer.
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [VAL_W-1:0] wdata;
		logic [IDX_W-1:0] raddr;
	} ram_ctl_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INSERT,
		ST_SCAN,
		ST_SHIFT,
		ST_NEXT,
		ST_RESP
	} state_t;

endpackage

@@ rtl/ovl_if.sv @@
// Valid/ready channel interfaces for requests and results.
// Depends on ovl_pkg for the payload types.
interface ovl_req_if;
	import ovl_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ovl_rsp_if;
	import ovl_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ovl_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No package dependencies.
module ovl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ rtl/ovl_ctrl.sv @@
// Sequencer of the ordered value list: walks the element store through its
// single read port, compares, shifts entries down and forms the result.
// Depends on ovl_pkg.
module ovl_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	input  ovl_pkg::req_t            req_data,
	output logic                     req_ready,
	output ovl_pkg::ram_ctl_t        ram_ctl,
	input  logic [ovl_pkg::VAL_W-1:0] rd_data,
	input  logic                     out_free,
	output logic                     res_valid,
	output ovl_pkg::rsp_t            res
);
	import ovl_pkg::*;

	state_t                  state_q, state_d;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        ptr_q;
	logic [IDX_W-1:0]        wp_q;
	logic                    pend_q;
	logic [1:0]              kind_q;
	logic signed [VAL_W-1:0] value_q;
	logic [1:0]              res_status_q;
	logic                    res_last_q;
	logic signed [VAL_W-1:0] res_next_q;

	logic accept;
	logic issue;
	logic hit;
	logic more;
	logic full;

	assign accept = req_valid && req_ready;
	assign more   = ptr_q < count_q;
	assign full   = count_q >= CNT_W'(CAPACITY);
	assign hit    = (state_q == ST_SCAN) && pend_q && (rd_data == value_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					unique case (req_data.kind)
						KIND_INSERT: state_d = full ? ST_RESP : ST_INSERT;
						KIND_DELETE: state_d = ST_SCAN;
						KIND_SEARCH: state_d = ST_SCAN;
						default:     state_d = ST_RESP;
					endcase
				end
			end
			ST_INSERT: state_d = ST_RESP;
			ST_SCAN: begin
				if (hit) begin
					if (kind_q == KIND_DELETE) begin
						state_d = ST_SHIFT;
					end else begin
						state_d = more ? ST_NEXT : ST_RESP;
					end
				end else if (!pend_q && !more) begin
					state_d = ST_RESP;
				end
			end
			ST_SHIFT: begin
				if (!pend_q && !more) begin
					state_d = ST_RESP;
				end
			end
			ST_NEXT: state_d = ST_RESP;
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs: handshake, store access and result fields.
	always_comb begin
		req_ready     = (state_q == ST_IDLE);
		res_valid     = (state_q == ST_RESP);
		issue         = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && more;
		ram_ctl.raddr = ptr_q[IDX_W-1:0];
		ram_ctl.we    = 1'b0;
		ram_ctl.waddr = wp_q;
		ram_ctl.wdata = rd_data;
		unique case (state_q)
			ST_INSERT: begin
				ram_ctl.we    = 1'b1;
				ram_ctl.waddr = count_q[IDX_W-1:0];
				ram_ctl.wdata = value_q;
			end
			ST_SHIFT: ram_ctl.we = pend_q;
			default: ;
		endcase
		res.status     = res_status_q;
		res.is_last    = res_last_q;
		res.next_value = res_next_q;
		res.count      = 5'(count_q);
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ptr_q   <= '0;
			wp_q    <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= issue;
			if (accept) begin
				ptr_q <= '0;
			end else if (issue) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			if (state_q == ST_INSERT) begin
				count_q <= count_q + CNT_W'(1);
			end
			// The hit entry sits one below the read pointer; the shift
			// writes from there onward.
			if (hit) begin
				wp_q <= IDX_W'(ptr_q - CNT_W'(1));
			end else if ((state_q == ST_SHIFT) && pend_q) begin
				wp_q <= wp_q + IDX_W'(1);
			end
			if ((state_q == ST_SHIFT) && !pend_q && !more) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Request and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q       <= req_data.kind;
			value_q      <= req_data.value;
			res_status_q <= ((req_data.kind == KIND_INSERT) && full) ? STAT_FULL : STAT_OK;
			res_last_q   <= 1'b0;
			res_next_q   <= '0;
		end
		if ((state_q == ST_SCAN) && !hit && !pend_q && !more) begin
			res_status_q <= STAT_ABSENT;
		end
		if (hit && (kind_q == KIND_SEARCH) && !more) begin
			res_last_q <= 1'b1;
		end
		if (state_q == ST_NEXT) begin
			res_next_q <= rd_data;
		end
	end
endmodule

@@ rtl/ordered_value_list_table_top.sv @@
// Top level of the ordered value list table: element store, sequencer and
// result register. Depends on ovl_pkg, ovl_if, ovl_ram and ovl_ctrl.
//
//   channel  dir  payload                              handshake
//   req      in   kind, value                          valid/ready
//   rsp      out  status, is_last, next_value, count   valid/ready
//
// A request that inserts into a full list or has the unused kind goes straight
// to the result, a plain insert first writes the new entry at the end of the
// list, and a search or delete walks the list through the single read port of
// the element store, one entry per cycle.
// Reset clears the element count and the sequencer; the store is not cleared.
// A result waits in the output register while the next request is taken;
// a stalled result holds the sequencer only when the next one is ready.
module ordered_value_list_table_top (
	input logic         clk,
	input logic         arst_n,
	ovl_req_if.sink     req,
	ovl_rsp_if.source   rsp
);
	import ovl_pkg::*;

	ram_ctl_t         ram_ctl;
	logic [VAL_W-1:0] rd_data;
	logic             res_valid;
	rsp_t             res;
	logic             out_free;
	logic             out_valid_q;
	rsp_t             out_data_q;

	assign out_free  = !out_valid_q || rsp.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_data_q;

	ovl_ram #(
		.WIDTH (VAL_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_ctl.we),
		.waddr (ram_ctl.waddr),
		.wdata (ram_ctl.wdata),
		.raddr (ram_ctl.raddr),
		.rdata (rd_data)
	);

	ovl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_data  (req.data),
		.req_ready (req.ready),
		.ram_ctl   (ram_ctl),
		.rd_data   (rd_data),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			out_data_q <= res;
		end
	end
endmodule
